>>> hw/rtl/grld_pkg.sv
// shared types and constants for the gray run-length decoder
`default_nettype none
package grld_pkg;

	// fixed field widths
	localparam int unsigned POS_W = 27;
	localparam int unsigned LEN_W = 28;
	localparam int unsigned DIM_W = 16;
	localparam int unsigned PROD_W = 2 * DIM_W;

	localparam int unsigned MAX_LAYER_PIXELS_DEF = 100000000;

	// configuration register indexes
	localparam logic [0:0] CFG_LAYER_WIDTH = 1'b0;
	localparam logic [0:0] CFG_LAYER_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_BAD_PREFIX = 3'd2,
		ST_SHORT_RUN = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_UNDERFILL = 3'd5,
		ST_BAD_DIMS = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_FIRST = 2'd1,
		PH_MORE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic end_of_blob;
	} grld_in_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [LEN_W-1:0] run_length;
		logic [POS_W-1:0] start_position;
		logic layer_done;
		status_t status;
	} grld_out_t;

	// layer size as seen by the parser
	typedef struct packed {
		logic bad;
		logic [POS_W-1:0] total;
	} grld_dims_t;

endpackage
`default_nettype wire

>>> hw/rtl/grld_dims.sv
// layer size registers with the pixel total formed at write time
`default_nettype none
module grld_dims
	import grld_pkg::*;
#(
	parameter int unsigned MAX_LAYER_PIXELS = MAX_LAYER_PIXELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [0:0] cfg_index,
	input wire logic [DIM_W-1:0] cfg_data,
	output grld_dims_t dims
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [PROD_W-1:0] total_q;
	logic [PROD_W-1:0] prod_w;
	logic [PROD_W-1:0] prod_h;

	// new value times the register that stays
	assign prod_w = PROD_W'(cfg_data) * PROD_W'(height_q);
	assign prod_h = PROD_W'(width_q) * PROD_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(1);
			height_q <= DIM_W'(1);
			total_q <= PROD_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LAYER_WIDTH: begin
					width_q <= cfg_data;
					total_q <= prod_w;
				end
				CFG_LAYER_HEIGHT: begin
					height_q <= cfg_data;
					total_q <= prod_h;
				end
				default: begin
				end
			endcase
		end
	end

	// a zero dimension shows as a zero product
	assign dims.bad = (total_q == '0) || (total_q > PROD_W'(MAX_LAYER_PIXELS));
	assign dims.total = total_q[POS_W-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/grld_parse.sv
// byte parser: layer state and the single-pass run decision
`default_nettype none
module grld_parse
	import grld_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire grld_in_t item,
	input wire grld_dims_t dims,
	output logic emit,
	output grld_out_t res
);

	phase_t phase_q, phase_n;
	logic [6:0] colour_q, colour_n;
	logic [LEN_W-1:0] acc_q, acc_n;
	logic [1:0] left_q, left_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic err_q, err_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			colour_q <= '0;
			acc_q <= '0;
			left_q <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			colour_q <= colour_n;
			acc_q <= acc_n;
			left_q <= left_n;
			pos_q <= pos_n;
			err_q <= err_n;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic last;
		logic fin;
		logic [LEN_W-1:0] fcount;
		logic fail;
		status_t fstat;
		logic clear;
		logic [LEN_W-1:0] acc_sh;
		logic [1:0] left_dec;
		logic [POS_W-1:0] room;
		logic [POS_W-1:0] pos_end;

		b = item.code_byte;
		last = item.end_of_blob;
		fin = 1'b0;
		fcount = '0;
		fail = 1'b0;
		fstat = ST_OK;
		clear = 1'b0;
		acc_sh = {acc_q[LEN_W-9:0], b};
		left_dec = left_q - 2'd1;
		room = dims.total - pos_q;
		pos_end = pos_q + fcount[POS_W-1:0];

		phase_n = phase_q;
		colour_n = colour_q;
		acc_n = acc_q;
		left_n = left_q;
		pos_n = pos_q;
		err_n = err_q;
		emit = 1'b0;
		res.pixel_value = '0;
		res.run_length = '0;
		res.start_position = pos_q;
		res.layer_done = 1'b1;
		res.status = ST_OK;

		// first pass: what the byte means
		if (err_q) begin
			clear = last;
		end else if (dims.bad) begin
			fail = 1'b1;
			fstat = ST_BAD_DIMS;
		end else begin
			unique case (phase_q)
				PH_FIRST: begin
					if (!b[7]) begin
						fin = 1'b1;
						fcount = (b < 8'd2) ? '0 : LEN_W'(b);
					end else if (b[7:6] == 2'b10) begin
						acc_n = LEN_W'(b[5:0]);
						left_n = 2'd1;
					end else if (b[7:5] == 3'b110) begin
						acc_n = LEN_W'(b[4:0]);
						left_n = 2'd2;
					end else if (b[7:4] == 4'b1110) begin
						acc_n = LEN_W'(b[3:0]);
						left_n = 2'd3;
					end else begin
						fail = 1'b1;
						fstat = ST_BAD_PREFIX;
					end
					if (!fin && !fail) begin
						if (last) begin
							fail = 1'b1;
							fstat = ST_TRUNCATED;
						end else begin
							phase_n = PH_MORE;
						end
					end
				end
				PH_MORE: begin
					acc_n = acc_sh;
					left_n = left_dec;
					if (left_dec == 2'd0) begin
						fin = 1'b1;
						fcount = (acc_sh < LEN_W'(2)) ? '0 : acc_sh;
					end else if (last) begin
						fail = 1'b1;
						fstat = ST_TRUNCATED;
					end
				end
				default: begin
					colour_n = b[6:0];
					if (!b[7]) begin
						fin = 1'b1;
						fcount = LEN_W'(1);
					end else if (last) begin
						fail = 1'b1;
						fstat = ST_TRUNCATED;
					end else begin
						phase_n = PH_FIRST;
						acc_n = '0;
						left_n = '0;
					end
				end
			endcase
		end

		// second pass: close a finished run
		pos_end = pos_q + fcount[POS_W-1:0];
		if (fin) begin
			phase_n = PH_CODE;
			left_n = '0;
			if (fcount == '0) begin
				fail = 1'b1;
				fstat = ST_SHORT_RUN;
			end else if ((pos_q >= dims.total) || (fcount > LEN_W'(room))) begin
				fail = 1'b1;
				fstat = ST_OVERFLOW;
			end else begin
				emit = 1'b1;
				res.pixel_value = (colour_n == '0) ? '0 : {colour_n, 1'b1};
				res.run_length = fcount;
				res.layer_done = last;
				res.status = (last && (pos_end != dims.total)) ? ST_UNDERFILL : ST_OK;
				pos_n = pos_end;
				clear = last;
			end
		end

		if (fail) begin
			emit = 1'b1;
			res.pixel_value = '0;
			res.run_length = '0;
			res.start_position = pos_q;
			res.layer_done = 1'b1;
			res.status = fstat;
			if (last) begin
				clear = 1'b1;
			end else begin
				err_n = 1'b1;
			end
		end

		if (clear) begin
			phase_n = PH_CODE;
			colour_n = '0;
			acc_n = '0;
			left_n = '0;
			pos_n = '0;
			err_n = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/gray_run_length_decoder_core.sv
// top level of the gray run-length decoder: handshake, stage registers, assertions
`default_nettype none
// Decodes a run-length coded layer of 7-bit gray pixels, one code byte per
// request. A byte with bit 7 clear is a single pixel; a byte with bit 7 set is a
// run marker followed by a one to four byte prefix-coded count. Every finished
// run gives one result with the expanded gray value, the length and the linear
// start index; the byte flagged end_of_blob closes the layer and checks the
// fill against layer_width * layer_height. The first error gives a result with
// layer_done set and its status, and bytes up to the one flagged last are then
// dropped. Rate: one byte per cycle while the result side does not stall; an
// accepted byte passes the input register, then the result register behind
// the one-pass decode. The pixel total is multiplied out when a size register
// is written, so a new item may follow a configuration write in the next cycle.
// Size registers may only be written while no request is in flight.
module gray_run_length_decoder_core
	import grld_pkg::*;
#(
	parameter int unsigned MAX_LAYER_PIXELS = MAX_LAYER_PIXELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic cfg_wr_en,
	input wire logic [0:0] cfg_index,
	input wire logic [DIM_W-1:0] cfg_data,
	// byte request channel
	input wire logic byte_valid,
	output logic byte_stall,
	input wire grld_in_t byte_req,
	// run result channel
	output logic run_valid,
	input wire logic run_stall,
	output grld_out_t run_res
);

	// input stage
	logic v_s1;
	grld_in_t item_s1;

	// result stage
	logic v_s2;
	grld_out_t res_s2;

	grld_dims_t dims;
	logic emit;
	grld_out_t res;
	logic adv;
	logic fire;
	logic take;

	// result register frees when empty or being taken
	assign adv = !v_s2 || !run_stall;
	// decode of the held byte happens when the result side can take it
	assign fire = v_s1 && adv;
	// input stage refills whenever it is empty or moving on
	assign byte_stall = v_s1 && !adv;
	assign take = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!byte_stall) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_req;
		end
	end

	grld_dims #(
		.MAX_LAYER_PIXELS(MAX_LAYER_PIXELS)
	) u_dims (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.dims(dims)
	);

	grld_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.dims(dims),
		.emit(emit),
		.res(res)
	);

	// result register, a byte that gives no run leaves it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_s2 <= res;
		end
	end

	assign run_valid = v_s2;
	assign run_res = res_s2;

	// a decoded run always lands in the result register on the next edge
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> run_valid)
		else $error("decoded run not presented");

	// every status other than ok closes the layer
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_res.status != ST_OK) |-> run_res.layer_done)
		else $error("error result without layer_done");

	// error results other than underfill carry no run
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_res.status != ST_OK) && (run_res.status != ST_UNDERFILL)
		|-> (run_res.run_length == '0) && (run_res.pixel_value == '0))
		else $error("error result carries a run");

	// a good run is never empty
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_res.status == ST_OK) |-> (run_res.run_length != '0))
		else $error("ok result with zero length");

endmodule
`default_nettype wire

>>> tb/gray_run_length_decoder_core_tb.sv
// self-checking testbench for the gray run-length decoder core
`default_nettype none
module gray_run_length_decoder_core_tb;
	import grld_pkg::*;

	// generous watchdog bound on the length of the whole simulation
	localparam int unsigned CYCLE_LIMIT = 500000;
	// random requests that the decoder actually acts on (dropped bytes excluded)
	localparam int unsigned RANDOM_BYTES = 600;
	// idle cycles after the last expected result, for bytes still inside that give none
	localparam int unsigned SETTLE_CYCLES = 4;
	// keep the log short if the core is badly broken
	localparam int unsigned PRINT_LIMIT = 100;

	// one row of the directed table: either a size write or a code byte
	typedef struct packed {
		bit is_cfg;
		logic [0:0] index;
		logic [DIM_W-1:0] data;	// code byte sits in the low eight bits
		logic last;
		bit typed;	// expectation typed in below rather than predicted
		bit gives;	// typed rows only: a result is due
		grld_out_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [0:0] cfg_index = CFG_LAYER_WIDTH;
	logic [DIM_W-1:0] cfg_data = '0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	grld_in_t byte_req = '0;
	logic run_valid;
	logic run_stall = 1'b0;
	grld_out_t run_res;

	// decoder state as predicted, reset values included
	logic [DIM_W-1:0] m_width = 16'd1;
	logic [DIM_W-1:0] m_height = 16'd1;
	phase_t m_phase = PH_CODE;
	logic [6:0] m_colour = '0;
	logic [LEN_W-1:0] m_acc = '0;
	logic [1:0] m_left = '0;
	logic [POS_W-1:0] m_pos = '0;
	logic m_err = 1'b0;

	grld_out_t expected_runs[$];
	grld_out_t next_run;
	stim_row_t plan[$];
	logic [7:0] blob[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned live_bytes = 0;
	int unsigned byte_idle_pct = 0;
	int unsigned run_stall_pct = 0;

	gray_run_length_decoder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_req(byte_req),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run_res(run_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// queue helpers: append at the tail
	// ---------------------------------------------------------------

	function automatic void add_expected(grld_out_t run);
		expected_runs.insert(expected_runs.size(), run);
	endfunction

	function automatic void add_row(stim_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic void add_byte(logic [7:0] code);
		blob.insert(blob.size(), code);
	endfunction

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic grld_out_t make_run(logic [7:0] value, logic [LEN_W-1:0] len,
			logic [POS_W-1:0] start, logic done, status_t st);
		grld_out_t run;
		run.pixel_value = value;
		run.run_length = len;
		run.start_position = start;
		run.layer_done = done;
		run.status = st;
		return run;
	endfunction

	// back to the start of a layer; the size registers are kept
	function automatic void clear_layer_state();
		m_phase = PH_CODE;
		m_colour = '0;
		m_acc = '0;
		m_left = '0;
		m_pos = '0;
		m_err = 1'b0;
	endfunction

	// error result carries the position reached; unless the blob ends here,
	// everything up to the last byte is swallowed
	function automatic grld_out_t flag_error(status_t st, logic last);
		grld_out_t run;
		run = make_run(8'h00, '0, m_pos, 1'b1, st);
		if (last) clear_layer_state();
		else m_err = 1'b1;
		return run;
	endfunction

	// a run length is known: range checks, then the run itself
	function automatic grld_out_t close_run(logic [LEN_W-1:0] count, longint unsigned total,
			logic last);
		logic [POS_W-1:0] start;
		logic [7:0] value;
		longint unsigned pos;
		grld_out_t run;
		start = m_pos;
		pos = m_pos;
		m_phase = PH_CODE;
		m_left = '0;
		if (count == '0) return flag_error(ST_SHORT_RUN, last);
		if (pos >= total || longint'(count) > total - pos) return flag_error(ST_OVERFLOW, last);
		// colour 0 stays black, anything else gets its low bit set
		value = (m_colour != '0) ? {m_colour, 1'b1} : 8'h00;
		m_pos = m_pos + count[POS_W-1:0];
		pos = m_pos;
		if (last) begin
			run = make_run(value, count, start, 1'b1, (pos == total) ? ST_OK : ST_UNDERFILL);
			clear_layer_state();
		end else begin
			run = make_run(value, count, start, 1'b0, ST_OK);
		end
		return run;
	endfunction

	// one accepted code byte; returns 1 when it yields a run result
	function automatic bit decode_byte(input grld_in_t req, output grld_out_t run);
		longint unsigned total;
		logic [7:0] b;
		logic last;
		bit gives;
		b = req.code_byte;
		last = req.end_of_blob;
		total = m_width;
		total = total * m_height;
		run = '0;
		gives = 1'b1;
		if (m_err) begin
			if (last) clear_layer_state();
			gives = 1'b0;
		end else if (m_width == '0 || m_height == '0 || total > MAX_LAYER_PIXELS_DEF) begin
			run = flag_error(ST_BAD_DIMS, last);
		end else if (m_phase == PH_FIRST) begin
			// first count byte: its prefix gives the count width
			if (!b[7]) begin
				run = close_run((b < 8'd2) ? 28'd0 : 28'(b), total, last);
			end else if (b[7:4] == 4'hf) begin
				run = flag_error(ST_BAD_PREFIX, last);
			end else begin
				if (!b[6]) begin
					m_acc = 28'(b[5:0]);
					m_left = 2'd1;
				end else if (!b[5]) begin
					m_acc = 28'(b[4:0]);
					m_left = 2'd2;
				end else begin
					m_acc = 28'(b[3:0]);
					m_left = 2'd3;
				end
				if (last) begin
					run = flag_error(ST_TRUNCATED, last);
				end else begin
					m_phase = PH_MORE;
					gives = 1'b0;
				end
			end
		end else if (m_phase == PH_MORE) begin
			m_acc = {m_acc[LEN_W-9:0], b};
			m_left = m_left - 2'd1;
			if (m_left == 2'd0) run = close_run((m_acc < 28'd2) ? 28'd0 : m_acc, total, last);
			else if (last) run = flag_error(ST_TRUNCATED, last);
			else gives = 1'b0;
		end else begin
			// code byte: single pixel or run marker
			m_colour = b[6:0];
			if (!b[7]) begin
				run = close_run(28'd1, total, last);
			end else if (last) begin
				run = flag_error(ST_TRUNCATED, last);
			end else begin
				m_phase = PH_FIRST;
				m_acc = '0;
				m_left = '0;
				gives = 1'b0;
			end
		end
		return gives;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: run result mismatch on %s: got %0h, expected %0h", $time, what, got,
				want);
	endtask

	// results are taken at the edge where valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && run_valid && !run_stall) begin
			if (expected_runs.size() == 0) begin
				report_mismatch("unrequested result (start)", run_res.start_position, 0);
			end else begin
				next_run = expected_runs.pop_front();
				if (run_res.pixel_value !== next_run.pixel_value)
					report_mismatch("pixel_value", run_res.pixel_value, next_run.pixel_value);
				if (run_res.run_length !== next_run.run_length)
					report_mismatch("run_length", run_res.run_length, next_run.run_length);
				if (run_res.start_position !== next_run.start_position)
					report_mismatch("start_position", run_res.start_position,
						next_run.start_position);
				if (run_res.layer_done !== next_run.layer_done)
					report_mismatch("layer_done", run_res.layer_done, next_run.layer_done);
				if (run_res.status !== next_run.status)
					report_mismatch("status", run_res.status, next_run.status);
			end
		end
	end

	// receiver back-pressure, independent of valid
	always @(posedge clk) begin
		run_stall <= (run_stall_pct != 0) && ($urandom_range(99) < run_stall_pct);
	end

	// watchdog: a hung core or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** gray_run_length_decoder_core: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------

	// present one byte request, hold it through stalls, predict on acceptance;
	// typed rows of the directed table queue their own expectation instead
	task automatic send_byte(logic [7:0] code, logic last, bit typed, bit gives,
			grld_out_t want);
		grld_in_t req;
		grld_out_t run;
		bit live;
		req.code_byte = code;
		req.end_of_blob = last;
		while ($urandom_range(99) < byte_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_req <= req;
		do @(posedge clk); while (byte_stall);
		live = !m_err;
		if (decode_byte(req, run) && !typed) add_expected(run);
		if (typed && gives) add_expected(want);
		if (live) live_bytes++;
	endtask

	// drop valid and let the pipeline empty; bytes without a result may still
	// be inside, hence the extra cycles
	task automatic settle();
		byte_valid <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// size register write; the core must be idle
	task automatic write_size(logic [0:0] idx, logic [DIM_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == CFG_LAYER_WIDTH) m_width = value;
		else m_height = value;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// directed table
	// ---------------------------------------------------------------

	function automatic stim_row_t cfg_row(logic [0:0] idx, logic [DIM_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.index = idx;
		row.data = value;
		return row;
	endfunction

	// checked against the predictor
	function automatic stim_row_t byte_row(logic [7:0] code, logic last);
		stim_row_t row;
		row = '0;
		row.data = 16'(code);
		row.last = last;
		return row;
	endfunction

	// typed: no result at all
	function automatic stim_row_t quiet_row(logic [7:0] code, logic last);
		stim_row_t row;
		row = byte_row(code, last);
		row.typed = 1'b1;
		return row;
	endfunction

	// typed: exactly this result
	function automatic stim_row_t run_row(logic [7:0] code, logic last, grld_out_t want);
		stim_row_t row;
		row = quiet_row(code, last);
		row.gives = 1'b1;
		row.want = want;
		return row;
	endfunction

	task automatic build_plan();
		// reset size is 1 x 1: single pixels, black and brightest
		add_row(run_row(8'h00, 1'b1, make_run(8'h00, 28'd1, 27'd0, 1'b1, ST_OK)));
		add_row(run_row(8'h7f, 1'b1, make_run(8'hff, 28'd1, 27'd0, 1'b1, ST_OK)));
		// second pixel of a one-pixel layer overflows
		add_row(run_row(8'h05, 1'b0, make_run(8'h0b, 28'd1, 27'd0, 1'b0, ST_OK)));
		add_row(run_row(8'h05, 1'b1, make_run(8'h00, 28'd0, 27'd1, 1'b1, ST_OVERFLOW)));
		// zero width, then the rest of the blob is swallowed
		add_row(cfg_row(CFG_LAYER_WIDTH, 16'd0));
		add_row(run_row(8'h12, 1'b0, make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_BAD_DIMS)));
		add_row(quiet_row(8'hff, 1'b1));
		// both sizes at their maximum: product beyond the pixel limit
		add_row(cfg_row(CFG_LAYER_WIDTH, 16'hffff));
		add_row(cfg_row(CFG_LAYER_HEIGHT, 16'hffff));
		add_row(run_row(8'h01, 1'b1, make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_BAD_DIMS)));
		// largest legal layer at full width, filled by one four-byte run
		add_row(cfg_row(CFG_LAYER_HEIGHT, 16'd1525));
		add_row(byte_row(8'hff, 1'b0));
		add_row(byte_row(8'he5, 1'b0));
		add_row(byte_row(8'hf4, 1'b0));
		add_row(byte_row(8'hfa, 1'b0));
		add_row(run_row(8'h0b, 1'b1,
			make_run(8'hff, 28'd99940875, 27'd0, 1'b1, ST_OK)));
		// largest count there is
		add_row(byte_row(8'h80, 1'b0));
		add_row(byte_row(8'hef, 1'b0));
		add_row(byte_row(8'hff, 1'b0));
		add_row(byte_row(8'hff, 1'b0));
		add_row(run_row(8'hff, 1'b1, make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_OVERFLOW)));
		// a 16 pixel layer for the parsing errors
		add_row(cfg_row(CFG_LAYER_WIDTH, 16'd16));
		add_row(cfg_row(CFG_LAYER_HEIGHT, 16'd1));
		add_row(byte_row(8'h81, 1'b0));
		add_row(run_row(8'hf0, 1'b0,
			make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_BAD_PREFIX)));
		add_row(quiet_row(8'h00, 1'b1));
		// run of one pixel is not allowed
		add_row(byte_row(8'h83, 1'b0));
		add_row(run_row(8'h01, 1'b1, make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_SHORT_RUN)));
		// two-byte count of three, then a closing pixel that leaves the layer short
		add_row(byte_row(8'h85, 1'b0));
		add_row(byte_row(8'h80, 1'b0));
		add_row(byte_row(8'h03, 1'b0));
		add_row(run_row(8'h09, 1'b1, make_run(8'h13, 28'd1, 27'd3, 1'b1, ST_UNDERFILL)));
		// blob ends straight after a run marker
		add_row(run_row(8'h88, 1'b1, make_run(8'h00, 28'd0, 27'd0, 1'b1, ST_TRUNCATED)));
	endtask

	// ---------------------------------------------------------------
	// random layers
	// ---------------------------------------------------------------

	// count bytes for a run, sometimes in a wider form than needed
	task automatic add_count(int unsigned count);
		logic [LEN_W-1:0] c;
		int unsigned n;
		c = count[LEN_W-1:0];
		n = (c < 28'd128) ? 1 : (c < 28'd16384) ? 2 : (c < 28'd2097152) ? 3 : 4;
		n = $urandom_range(4, n);
		case (n)
			1: begin
				add_byte({1'b0, c[6:0]});
			end
			2: begin
				add_byte({2'b10, c[13:8]});
				add_byte(c[7:0]);
			end
			3: begin
				add_byte({3'b110, c[20:16]});
				add_byte(c[15:8]);
				add_byte(c[7:0]);
			end
			default: begin
				add_byte({4'b1110, c[27:24]});
				add_byte(c[23:16]);
				add_byte(c[15:8]);
				add_byte(c[7:0]);
			end
		endcase
	endtask

	// new layer size: mostly small, some large, now and then illegal
	task automatic resize_layer(bit one_reg);
		int unsigned sel, w, h, lim;
		sel = $urandom_range(15);
		if (sel == 0) begin
			w = $urandom_range(1) ? 0 : $urandom_range(1, 16);
			h = (w == 0) ? $urandom_range(1, 8) : 0;
		end else if (sel == 1) begin
			w = $urandom_range(10001, 65535);
			h = $urandom_range(10001, 65535);
		end else if (sel <= 3) begin
			w = $urandom_range(1, 65535);
			lim = MAX_LAYER_PIXELS_DEF / w;
			if (lim > 65535) lim = 65535;
			h = $urandom_range(1, lim);
		end else begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 8);
		end
		settle();
		if (!one_reg) begin
			write_size(CFG_LAYER_WIDTH, w[DIM_W-1:0]);
			write_size(CFG_LAYER_HEIGHT, h[DIM_W-1:0]);
		end else if ($urandom_range(1)) begin
			write_size(CFG_LAYER_WIDTH, w[DIM_W-1:0]);
		end else begin
			write_size(CFG_LAYER_HEIGHT, h[DIM_W-1:0]);
		end
	endtask

	// one blob: mostly a well-formed fill of the layer, a quarter of them with
	// one fault somewhere in the first few runs
	task automatic play_layer();
		longint unsigned total;
		int unsigned left, len, fault, fault_at, runs, mark, drop;
		int cut;
		logic [6:0] colour;
		total = m_width;
		total = total * m_height;
		blob.delete();
		if (total == 0 || total > MAX_LAYER_PIXELS_DEF) begin
			// size is illegal: any bytes will do
			repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
		end else begin
			fault = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
			fault_at = $urandom_range(3);
			left = 32'(total);
			runs = 0;
			while (left != 0 && blob.size() < 48) begin
				colour = 7'($urandom_range(127));
				if (fault != 0 && runs == fault_at) begin
					case (fault)
						1: begin
							// run of zero or one pixel
							add_byte({1'b1, colour});
							add_count($urandom_range(1));
						end
						2: begin
							// count prefix that does not exist
							add_byte({1'b1, colour});
							add_byte({4'hf, 4'($urandom_range(15))});
						end
						3: begin
							// blob ends inside a run
							add_byte({1'b1, colour});
							mark = blob.size();
							add_count($urandom_range(2, 300000));
							drop = $urandom_range(1, blob.size() - mark);
							repeat (drop) void'(blob.pop_back());
						end
						4: begin
							// run past the end of the layer
							add_byte({1'b1, colour});
							add_count(left + $urandom_range(1, 5));
						end
						5: begin
							// blob ends before the layer is full
						end
						default: begin
							// noise, then carry on
							repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
							fault = 0;
						end
					endcase
					if (fault == 1 || fault == 2 || fault == 4)
						repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
					if (fault != 0) break;
					runs++;
				end else begin
					if (total <= 512) len = $urandom_range(1, (left < 40) ? left : 40);
					else len = $urandom_range(1) ? left : $urandom_range(1, left);
					if (len == 1) begin
						add_byte({1'b0, colour});
					end else begin
						add_byte({1'b1, colour});
						add_count(len);
					end
					left = left - len;
					runs++;
				end
			end
			if (blob.size() == 0) add_byte({1'b0, 7'($urandom_range(127))});
		end
		// now and then one size register changes in the middle of the blob
		cut = ($urandom_range(39) == 0) ? int'($urandom_range(blob.size() - 1)) : -1;
		foreach (blob[i]) begin
			if (i == cut) resize_layer(1'b1);
			send_byte(blob[i], i == blob.size() - 1, 1'b0, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// sequence of the run
	// ---------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, under the first idling pattern
		byte_idle_pct = 16;
		run_stall_pct = 61;
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_size(plan[i].index, plan[i].data);
			end else begin
				send_byte(plan[i].data[7:0], plan[i].last, plan[i].typed, plan[i].gives,
					plan[i].want);
			end
		end

		// random part: sender idles lightly and receiver heavily, then the
		// reverse, then full rate both ways
		live_bytes = 0;
		while (live_bytes < RANDOM_BYTES) begin
			if (live_bytes < RANDOM_BYTES / 3) begin
				byte_idle_pct = 16;
				run_stall_pct = 61;
			end else if (live_bytes < 2 * RANDOM_BYTES / 3) begin
				byte_idle_pct = 61;
				run_stall_pct = 16;
			end else begin
				byte_idle_pct = 0;
				run_stall_pct = 0;
			end
			if ($urandom_range(2) == 0) resize_layer(1'b0);
			play_layer();
		end

		// everything out, then a few quiet cycles for stray results
		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** gray_run_length_decoder_core: PASSED **");
		end else begin
			$display("** gray_run_length_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/grld_pkg.sv
hw/rtl/grld_dims.sv
hw/rtl/grld_parse.sv
hw/rtl/gray_run_length_decoder_core.sv
tb/gray_run_length_decoder_core_tb.sv
